/* rtl/matrix4_multiply_row_assert.svh */
// assertion macros used by the checker file
`ifndef MATRIX4_MULTIPLY_ROW_ASSERT_SVH
`define MATRIX4_MULTIPLY_ROW_ASSERT_SVH

// same-cycle implication, checked out of reset
`define M4MR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define M4MR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/m4mr_pkg.sv */
// types and constants of the 4x4 row multiplier
`timescale 1ns / 1ps
`default_nettype none
package m4mr_pkg;
	localparam int DIM    = 4;
	localparam int ELEM_W = 32;
	localparam int ROW_W  = $clog2(DIM);
	localparam int PROD_W = 2 * ELEM_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + $clog2(DIM);
	localparam int HALF   = DIM / 2;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [ROW_W-1:0]         row_idx_t;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_MUL  = 1'b1
	} action_t;

	localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
endpackage
`default_nettype wire

/* rtl/m4mr_in_if.sv */
// input channel: load or multiply word carrying one matrix row
`timescale 1ns / 1ps
`default_nettype none
interface m4mr_in_if;
	import m4mr_pkg::*;
	logic     valid;
	logic     ready;
	logic     action;
	row_idx_t row_index;
	elem_t    elem_0;
	elem_t    elem_1;
	elem_t    elem_2;
	elem_t    elem_3;

	modport source (output valid, action, row_index, elem_0, elem_1, elem_2, elem_3,
		input ready);
	modport sink (input valid, action, row_index, elem_0, elem_1, elem_2, elem_3,
		output ready);
endinterface
`default_nettype wire

/* rtl/m4mr_out_if.sv */
// output channel: one result row with overflow flag
`timescale 1ns / 1ps
`default_nettype none
interface m4mr_out_if;
	import m4mr_pkg::*;
	logic  valid;
	logic  ready;
	elem_t out_0;
	elem_t out_1;
	elem_t out_2;
	elem_t out_3;
	logic  overflow;

	modport source (output valid, out_0, out_1, out_2, out_3, overflow, input ready);
	modport sink (input valid, out_0, out_1, out_2, out_3, overflow, output ready);
endinterface
`default_nettype wire

/* rtl/m4mr_mul.sv */
// stored matrix and first stage: sixteen products of row and columns
`timescale 1ns / 1ps
`default_nettype none
module m4mr_mul (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	output                     logic in_ready,
	input  wire                logic action,
	input  wire m4mr_pkg::row_idx_t  row_index,
	input  wire m4mr_pkg::elem_t     elems [m4mr_pkg::DIM],
	output                     logic out_valid,
	input  wire                logic out_ready,
	output      m4mr_pkg::prod_t     prod_s1 [m4mr_pkg::DIM][m4mr_pkg::DIM]
);
	import m4mr_pkg::*;

	elem_t mat_q [DIM][DIM];
	logic  valid_s1;
	logic  take;

	assign in_ready  = !valid_s1 || out_ready;
	assign take      = in_valid && in_ready;
	assign out_valid = valid_s1;

	// stored rows, no reset
	always_ff @(posedge clk) begin
		if (take && action == ACT_LOAD) begin
			for (int k = 0; k < DIM; k++) begin
				mat_q[row_index][k] <= elems[k];
			end
		end
	end

	// prod_s1[j][k] = a_k * b[k][j]
	always_ff @(posedge clk) begin
		if (take) begin
			for (int j = 0; j < DIM; j++) begin
				for (int k = 0; k < DIM; k++) begin
					prod_s1[j][k] <= elems[k] * mat_q[k][j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && action == ACT_MUL;
		end
	end
endmodule
`default_nettype wire

/* rtl/m4mr_add.sv */
// second stage: pairwise sums of products per column
`timescale 1ns / 1ps
`default_nettype none
module m4mr_add (
	input  wire             logic clk,
	input  wire             logic arst_n,
	input  wire             logic in_valid,
	output                  logic in_ready,
	input  wire m4mr_pkg::prod_t  prod_s1 [m4mr_pkg::DIM][m4mr_pkg::DIM],
	output                  logic out_valid,
	input  wire             logic out_ready,
	output      m4mr_pkg::pair_t  pair_s2 [m4mr_pkg::DIM][m4mr_pkg::HALF]
);
	import m4mr_pkg::*;

	logic valid_s2;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int j = 0; j < DIM; j++) begin
				for (int h = 0; h < HALF; h++) begin
					pair_s2[j][h] <= PAIR_W'(prod_s1[j][2*h]) + PAIR_W'(prod_s1[j][2*h+1]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end
endmodule
`default_nettype wire

/* rtl/m4mr_sat.sv */
// third stage: final sum, floor shift and saturation, output register
`timescale 1ns / 1ps
`default_nettype none
module m4mr_sat #(
	parameter int FRAC_BITS = 16
) (
	input  wire             logic clk,
	input  wire             logic arst_n,
	input  wire             logic in_valid,
	output                  logic in_ready,
	input  wire m4mr_pkg::pair_t  pair_s2 [m4mr_pkg::DIM][m4mr_pkg::HALF],
	output                  logic out_valid,
	input  wire             logic out_ready,
	output      m4mr_pkg::elem_t  res_s3 [m4mr_pkg::DIM],
	output                  logic ovf_s3
);
	import m4mr_pkg::*;

	localparam int HI_W = SUM_W - ELEM_W + 1;

	logic  valid_s3;
	sum_t  total   [DIM];
	sum_t  shifted [DIM];
	elem_t col     [DIM];
	logic  [DIM-1:0] sat;

	assign in_ready  = !valid_s3 || out_ready;
	assign out_valid = valid_s3;

	always_comb begin
		for (int j = 0; j < DIM; j++) begin
			total[j]   = SUM_W'(pair_s2[j][0]) + SUM_W'(pair_s2[j][1]);
			shifted[j] = total[j] >>> FRAC_BITS;
			sat[j]     = !((&shifted[j][SUM_W-1 -: HI_W]) || !(|shifted[j][SUM_W-1 -: HI_W]));
			if (!sat[j]) begin
				col[j] = shifted[j][ELEM_W-1:0];
			end else if (shifted[j][SUM_W-1]) begin
				col[j] = ELEM_MIN;
			end else begin
				col[j] = ELEM_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_s3 <= col;
			ovf_s3 <= |sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end
endmodule
`default_nettype wire

/* rtl/matrix4_multiply_row.sv */
// top level: 4x4 fixed-point matrix row multiplier
//
//  channel  dir  contents
//  in_row   in   action, row_index, elem_0..elem_3
//  out_row  out  out_0..out_3, overflow
//
// one word per cycle on in_row, loads and multiplies alike, unless a stall on out_row backs up to the first stage
// a multiply word reaches out_row through the registers of the product,
// pair-sum and final-sum/saturate stages, in that order
// a load word updates the stored row at its acceptance edge and makes no output word
// reset clears the stage valid bits only; stored rows hold nothing until loaded
// a stall on out_row holds each stage that is full; empty stages keep filling
`timescale 1ns / 1ps
`default_nettype none
module matrix4_multiply_row #(
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	m4mr_in_if.sink  in_row,
	m4mr_out_if.source out_row
);
	import m4mr_pkg::*;

	elem_t elems [DIM];
	prod_t prod_s1 [DIM][DIM];
	pair_t pair_s2 [DIM][HALF];
	elem_t res_s3 [DIM];
	logic  ovf_s3;
	logic  v1;
	logic  r2;
	logic  v2;
	logic  r3;

	assign elems[0] = in_row.elem_0;
	assign elems[1] = in_row.elem_1;
	assign elems[2] = in_row.elem_2;
	assign elems[3] = in_row.elem_3;

	m4mr_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_row.valid),
		.in_ready  (in_row.ready),
		.action    (in_row.action),
		.row_index (in_row.row_index),
		.elems     (elems),
		.out_valid (v1),
		.out_ready (r2),
		.prod_s1   (prod_s1)
	);

	m4mr_add u_add (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r2),
		.prod_s1   (prod_s1),
		.out_valid (v2),
		.out_ready (r3),
		.pair_s2   (pair_s2)
	);

	m4mr_sat #(
		.FRAC_BITS (FRAC_BITS)
	) u_sat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r3),
		.pair_s2   (pair_s2),
		.out_valid (out_row.valid),
		.out_ready (out_row.ready),
		.res_s3    (res_s3),
		.ovf_s3    (ovf_s3)
	);

	assign out_row.out_0    = res_s3[0];
	assign out_row.out_1    = res_s3[1];
	assign out_row.out_2    = res_s3[2];
	assign out_row.out_3    = res_s3[3];
	assign out_row.overflow = ovf_s3;
endmodule
`default_nettype wire

/* rtl/m4mr_checker.sv */
// port-level checks of the row multiplier and their binding
`timescale 1ns / 1ps
`default_nettype none
`include "matrix4_multiply_row_assert.svh"
module m4mr_checker (
	input wire             logic clk,
	input wire             logic arst_n,
	input wire             logic in_valid,
	input wire             logic in_ready,
	input wire             logic in_action,
	input wire             logic out_valid,
	input wire             logic out_ready,
	input wire m4mr_pkg::elem_t  out_0,
	input wire m4mr_pkg::elem_t  out_1,
	input wire m4mr_pkg::elem_t  out_2,
	input wire m4mr_pkg::elem_t  out_3,
	input wire             logic overflow
);
	import m4mr_pkg::*;

	logic [4*ELEM_W:0] out_word;
	logic              out_stall;
	logic              mul_take;
	logic              sat_seen;

	assign out_word  = {out_0, out_1, out_2, out_3, overflow};
	assign out_stall = out_valid && !out_ready;
	assign mul_take  = in_valid && in_ready && in_action == ACT_MUL;
	assign sat_seen  = out_0 == ELEM_MAX || out_0 == ELEM_MIN ||
		out_1 == ELEM_MAX || out_1 == ELEM_MIN ||
		out_2 == ELEM_MAX || out_2 == ELEM_MIN ||
		out_3 == ELEM_MAX || out_3 == ELEM_MIN;

	// held word stays put
	`M4MR_ASSERT_NEXT(out_hold_a, out_stall, out_valid && $stable(out_word), "held word changed")
	// free output means no backpressure at the input
	`M4MR_ASSERT_IMPL(ready_a, out_ready, in_ready, "input not ready while output is free")
	// unstalled multiply word arrives: out_ready high as it moves into the pair-sum and final stages
	`M4MR_ASSERT_NEXT(latency_a, mul_take ##1 out_ready ##1 out_ready, out_valid, "multiply word late")
	// overflow only with a saturated column
	`M4MR_ASSERT_IMPL(ovf_a, out_valid && overflow, sat_seen, "overflow without a saturated column")
endmodule

bind matrix4_multiply_row m4mr_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_row.valid),
	.in_ready  (in_row.ready),
	.in_action (in_row.action),
	.out_valid (out_row.valid),
	.out_ready (out_row.ready),
	.out_0     (out_row.out_0),
	.out_1     (out_row.out_1),
	.out_2     (out_row.out_2),
	.out_3     (out_row.out_3),
	.overflow  (out_row.overflow)
);
`default_nettype wire
